>>> design/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// shared constants and the arctangent table of the tilt filter
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_LEN     = 24;
    localparam int IDX_W        = $clog2(ATAN_LEN);

    localparam logic [15:0] WEIGHT_RESET = 16'd64225;

    function automatic logic [21:0] atan_entry(input logic [IDX_W-1:0] idx);
        logic [21:0] r;
        case (idx)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234379;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

>>> design/tcf_if.sv
// ----------------------------------------------------------------------------
// tcf channel interfaces
// sample, result and weight write channels with valid and ready
// ----------------------------------------------------------------------------
interface tcf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_rate_x;
    logic signed [15:0] gyro_rate_y;
    logic        [19:0] elapsed_us;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_rate_x, gyro_rate_y,
                    elapsed_us, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, gyro_rate_x, gyro_rate_y,
                    elapsed_us, output ready);
endinterface

interface tcf_result_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] roll_out;
    logic signed [16:0] pitch_out;
    modport source (output valid, roll_out, pitch_out, input ready);
    modport sink   (input valid, roll_out, pitch_out, output ready);
endinterface

interface tcf_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> design/tcf_cordic.sv
// ----------------------------------------------------------------------------
// tcf_cordic
// iterative vectoring cordic, atan2(y, x) in 1/256 degree, one step a cycle
// ----------------------------------------------------------------------------
module tcf_cordic
    import tcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] y_in,
    input  logic signed [15:0] x_in,
    output logic               done,
    output logic signed [16:0] angle
);

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_RUN  = 3'b010,
        C_FIN  = 3'b100
    } cstate_t;

    localparam logic signed [25:0] QUARTER_Z = 26'sd5898240;
    localparam logic signed [25:0] HALF_A    = 26'sd46080;

    cstate_t                state_reg;
    logic signed [27:0]     x_reg, y_reg;
    logic signed [25:0]     z_reg;
    logic [IDX_W-1:0]       i_reg;
    logic                   zero_reg;
    logic                   done_reg;
    logic signed [16:0]     angle_reg;

    logic signed [27:0]     xs, ys, dx, dy;
    logic signed [25:0]     at, zr;

    assign xs = {{4{x_in[15]}}, x_in, 8'b0};
    assign ys = {{4{y_in[15]}}, y_in, 8'b0};
    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign at = signed'({4'b0, atan_entry(i_reg)});
    assign zr = (z_reg + 26'sd128) >>> 8;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= C_RUN;
                    end
                end
                C_RUN:
                begin
                    if (i_reg == IDX_W'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= C_FIN;
                    end
                end
                C_FIN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            C_IDLE:
            begin
                i_reg    <= '0;
                zero_reg <= (x_in == 16'sd0) && (y_in == 16'sd0);
                if (x_in < 16'sd0)
                begin
                    if (y_in >= 16'sd0)
                    begin
                        x_reg <= ys;
                        y_reg <= -xs;
                        z_reg <= QUARTER_Z;
                    end
                    else
                    begin
                        x_reg <= -ys;
                        y_reg <= xs;
                        z_reg <= -QUARTER_Z;
                    end
                end
                else
                begin
                    x_reg <= xs;
                    y_reg <= ys;
                    z_reg <= '0;
                end
            end
            C_RUN:
            begin
                i_reg <= i_reg + 1'b1;
                if (y_reg >= 28'sd0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
            end
            C_FIN:
            begin
                if (zero_reg)
                begin
                    angle_reg <= '0;
                end
                else if (zr > HALF_A)
                begin
                    angle_reg <= HALF_A[16:0];
                end
                else if (zr < -HALF_A)
                begin
                    angle_reg <= -HALF_A[16:0];
                end
                else
                begin
                    angle_reg <= zr[16:0];
                end
            end
            default:
            begin
                i_reg <= '0;
            end
        endcase
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

>>> design/tcf_rdiv.sv
// ----------------------------------------------------------------------------
// tcf_rdiv
// gyro step: round(rate * elapsed / 62500) by a reciprocal multiply
// ----------------------------------------------------------------------------
module tcf_rdiv
    import tcf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [15:0] rate,
    input  logic        [19:0] dt,
    output logic               done,
    output logic signed [20:0] delta
);

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_MAG  = 5'b00010,
        D_LO   = 5'b00100,
        D_HI   = 5'b01000,
        D_SUM  = 5'b10000
    } dstate_t;

    // ceil(2^47 / 15625) split in two 17-bit halves
    localparam logic [34:0] HALF_D   = 35'd31250;
    localparam logic [16:0] RECIP_LO = 17'd62487;
    localparam logic [16:0] RECIP_HI = 17'd68719;

    dstate_t            state_reg;
    logic signed [36:0] prod_reg;
    logic [32:0]        m_reg;
    logic [49:0]        lo_reg;
    logic [49:0]        hi_reg;
    logic [19:0]        q_reg;
    logic               neg_reg;
    logic               done_reg;

    logic signed [36:0] abs_prod;
    logic [34:0]        rnd;
    logic [49:0]        mul_out;
    logic [66:0]        sum;

    assign abs_prod = prod_reg[36] ? -prod_reg : prod_reg;
    assign rnd      = abs_prod[34:0] + HALF_D;
    assign mul_out  = m_reg * ((state_reg == D_HI) ? RECIP_HI : RECIP_LO);
    assign sum      = {17'b0, lo_reg} + {hi_reg, 17'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= D_MAG;
                    end
                end
                D_MAG:
                begin
                    state_reg <= D_LO;
                end
                D_LO:
                begin
                    state_reg <= D_HI;
                end
                D_HI:
                begin
                    state_reg <= D_SUM;
                end
                D_SUM:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                prod_reg <= 37'(rate * signed'({1'b0, dt}));
            end
            D_MAG:
            begin
                neg_reg <= prod_reg[36];
                m_reg   <= rnd[34:2];
            end
            D_LO:
            begin
                lo_reg <= mul_out;
            end
            D_HI:
            begin
                hi_reg <= mul_out;
            end
            D_SUM:
            begin
                q_reg <= sum[66:47];
            end
            default:
            begin
                q_reg <= '0;
            end
        endcase
    end

    assign done  = done_reg;
    assign delta = neg_reg ? -signed'({1'b0, q_reg}) : signed'({1'b0, q_reg});

endmodule

>>> design/tilt_complementary_filter_top.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter_top
// roll and pitch complementary filter with a shared iterative cordic
// ----------------------------------------------------------------------------
// One sample item gives one result item of roll and pitch in 1/256 degree.
// The block takes one sample at a time: the first sample after reset runs
// only the cordic for the two accel angles, every later one also the
// reciprocal-multiply rounding divider for the two gyro steps and the
// unwrap, blend and 4-step wrap of each angle. A result that waits on the
// result channel adds its wait. The next sample is taken as soon as the
// sequencer is back in idle, even while the previous result still waits
// on the result channel.
module tilt_complementary_filter_top
    import tcf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    tcf_sample_if.sink   sample,
    tcf_result_if.source result,
    tcf_cfg_if.sink      cfg
);

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_CRS  = 14'b00000000000010,
        S_CRW  = 14'b00000000000100,
        S_CPS  = 14'b00000000001000,
        S_CPW  = 14'b00000000010000,
        S_DRS  = 14'b00000000100000,
        S_DRW  = 14'b00000001000000,
        S_DPS  = 14'b00000010000000,
        S_DPW  = 14'b00000100000000,
        S_UNW  = 14'b00001000000000,
        S_MUL1 = 14'b00010000000000,
        S_MUL2 = 14'b00100000000000,
        S_WRAP = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } state_t;

    localparam logic signed [22:0] QT23 = 23'sd23040;
    localparam logic signed [22:0] FT23 = 23'sd92160;
    localparam logic signed [23:0] HT24 = 24'sd46080;
    localparam logic signed [23:0] FT24 = 24'sd92160;

    state_t              state_reg;
    logic                started_reg;
    logic [15:0]         weight_reg;
    logic signed [15:0]  ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [19:0]         dt_reg;
    logic signed [16:0]  acc_roll_reg, acc_pitch_reg;
    logic signed [16:0]  roll_reg, pitch_reg;
    logic signed [22:0]  g_roll_reg, g_pitch_reg, work_reg;
    logic signed [40:0]  prod_reg;
    logic signed [23:0]  v_reg;
    logic [1:0]          k_reg;
    logic                sel_reg;
    logic                res_valid_reg;
    logic signed [16:0]  res_roll_reg, res_pitch_reg;

    logic                cor_done, div_done;
    logic signed [16:0]  cor_angle;
    logic signed [20:0]  div_delta;
    logic signed [22:0]  cur_g, ug;
    logic signed [16:0]  cur_acc;
    logic signed [22:0]  acc23;
    logic signed [41:0]  blend_sum;
    logic signed [34:0]  acc_prod;
    logic signed [23:0]  fk, t_sub, t_add, v_wrap;
    logic                out_free;

    tcf_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_CRS || state_reg == S_CPS),
        .y_in  ((state_reg == S_CPS) ? ay_reg : ax_reg),
        .x_in  (az_reg),
        .done  (cor_done),
        .angle (cor_angle)
    );

    tcf_rdiv u_rdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_DRS || state_reg == S_DPS),
        .rate  ((state_reg == S_DPS) ? gy_reg : gx_reg),
        .dt    (dt_reg),
        .done  (div_done),
        .delta (div_delta)
    );

    assign cur_g   = sel_reg ? g_pitch_reg : g_roll_reg;
    assign cur_acc = sel_reg ? acc_pitch_reg : acc_roll_reg;
    assign acc23   = 23'(cur_acc);

    always_comb
    begin
        ug = cur_g;
        if (acc23 > QT23 && cur_g < -QT23)
        begin
            ug = cur_g + FT23;
        end
        if (acc23 < -QT23 && cur_g > QT23)
        begin
            ug = cur_g - FT23;
        end
    end

    assign acc_prod  = 35'(signed'({1'b0, 17'(18'h10000 - 18'(weight_reg))}) * cur_acc);
    assign blend_sum = 42'(prod_reg) + 42'(acc_prod) + 42'sd32768;
    assign fk        = FT24 <<< k_reg;
    assign t_sub     = v_reg - fk;
    assign t_add     = v_reg + fk;
    assign v_wrap    = (v_reg > 24'sd0) ? ((t_sub > -HT24) ? t_sub : v_reg)
                                        : ((t_add < HT24) ? t_add : v_reg);
    assign out_free  = !res_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            started_reg   <= 1'b0;
            weight_reg    <= WEIGHT_RESET;
            roll_reg      <= '0;
            pitch_reg     <= '0;
            res_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                weight_reg <= cfg.data;
            end
            if (result.ready && state_reg != S_OUT)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample.valid)
                    begin
                        state_reg <= S_CRS;
                    end
                end
                S_CRS:
                begin
                    state_reg <= S_CRW;
                end
                S_CRW:
                begin
                    if (cor_done)
                    begin
                        state_reg <= S_CPS;
                    end
                end
                S_CPS:
                begin
                    state_reg <= S_CPW;
                end
                S_CPW:
                begin
                    if (cor_done)
                    begin
                        if (!started_reg)
                        begin
                            roll_reg    <= acc_roll_reg;
                            pitch_reg   <= cor_angle;
                            started_reg <= 1'b1;
                            state_reg   <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_DRS;
                        end
                    end
                end
                S_DRS:
                begin
                    state_reg <= S_DRW;
                end
                S_DRW:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_DPS;
                    end
                end
                S_DPS:
                begin
                    state_reg <= S_DPW;
                end
                S_DPW:
                begin
                    if (div_done)
                    begin
                        sel_reg   <= 1'b0;
                        state_reg <= S_UNW;
                    end
                end
                S_UNW:
                begin
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_WRAP;
                end
                S_WRAP:
                begin
                    if (k_reg == 2'd0)
                    begin
                        if (sel_reg)
                        begin
                            pitch_reg <= v_wrap[16:0];
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            roll_reg  <= v_wrap[16:0];
                            sel_reg   <= 1'b1;
                            state_reg <= S_UNW;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && sample.valid)
        begin
            ax_reg <= sample.accel_x;
            ay_reg <= sample.accel_y;
            az_reg <= sample.accel_z;
            gx_reg <= sample.gyro_rate_x;
            gy_reg <= sample.gyro_rate_y;
            dt_reg <= sample.elapsed_us;
        end
        if (state_reg == S_CRW && cor_done)
        begin
            acc_roll_reg <= cor_angle;
        end
        if (state_reg == S_CPW && cor_done)
        begin
            acc_pitch_reg <= cor_angle;
        end
        if (state_reg == S_DRW && div_done)
        begin
            g_roll_reg <= 23'(roll_reg) + 23'(div_delta);
        end
        if (state_reg == S_DPW && div_done)
        begin
            g_pitch_reg <= 23'(pitch_reg) - 23'(div_delta);
        end
        if (state_reg == S_UNW)
        begin
            work_reg <= ug;
        end
        if (state_reg == S_MUL1)
        begin
            prod_reg <= 41'(signed'({1'b0, weight_reg}) * work_reg);
        end
        if (state_reg == S_MUL2)
        begin
            v_reg <= blend_sum[39:16];
            k_reg <= 2'd3;
        end
        if (state_reg == S_WRAP)
        begin
            k_reg <= k_reg - 1'b1;
            v_reg <= v_wrap;
        end
        if (state_reg == S_OUT && out_free)
        begin
            res_roll_reg  <= roll_reg;
            res_pitch_reg <= pitch_reg;
        end
    end

    assign sample.ready     = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign result.valid     = res_valid_reg;
    assign result.roll_out  = res_roll_reg;
    assign result.pitch_out = res_pitch_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample.valid && sample.ready) |=> !sample.ready)
        else $error("sample taken while busy");

    a_result_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> started_reg)
        else $error("result before any sample");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.roll_out <= 17'sd46080 && result.roll_out >= -17'sd46080))
        else $error("roll out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.pitch_out <= 17'sd46080 && result.pitch_out >= -17'sd46080))
        else $error("pitch out of range");
`endif

endmodule

>>> tb/tb_tilt_complementary_filter_top.sv
// ----------------------------------------------------------------------------
// tb_tilt_complementary_filter_top
// self-checking bench for the roll and pitch complementary filter: a directed
// table then random samples, each result checked against typed angles or
// an in-bench predictor of the cordic, integration, unwrap, blend and wrap
// ----------------------------------------------------------------------------
module tb_tilt_complementary_filter_top;
    import tcf_pkg::*;

    localparam int LIMIT      = 6000;
    localparam int DRAIN_WAIT = 200;
    localparam int HALF       = 46080;
    localparam int FULL       = 92160;
    localparam int QUARTER    = 23040;

    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic        [19:0] dt;
        bit                 typed;
        logic signed [16:0] roll;
        logic signed [16:0] pitch;
    } sample_row_t;

    typedef struct {
        bit                 typed;
        logic signed [16:0] roll;
        logic signed [16:0] pitch;
    } angles_t;

    logic clk;
    logic rst_n;

    tcf_sample_if sample ();
    tcf_result_if result ();
    tcf_cfg_if    cfg ();

    tilt_complementary_filter_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    longint atan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                             29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                             57, 29, 14, 7, 4, 2, 1, 0};

    bit          tilt_started;
    longint      roll_angle;
    longint      pitch_angle;
    logic [15:0] gyro_w;

    angles_t     typed_q[$];
    angles_t     angles_q[$];
    int          errors;
    int          idle_count;
    int          src_idle;
    int          snk_idle;
    int          hold_left;
    bit          hold_req;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic longint accel_angle(longint y, longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        int     steps;
        z = 0;
        steps = CORDIC_STEPS < 24 ? CORDIC_STEPS : 24;
        if (x == 0 && y == 0)
            return 0;
        x = x * 256;
        y = y * 256;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end
            else begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_deg[i];
            end
            else begin
                x -= dx; y += dy; z -= atan_deg[i];
            end
        end
        z = (z + 128) >>> 8;
        if (z > HALF) z = HALF;
        if (z < -HALF) z = -HALF;
        return z;
    endfunction

    function automatic longint gyro_delta(longint num);
        longint mag;
        longint q;
        mag = num < 0 ? -num : num;
        q = (mag + 31250) / 62500;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint fuse_angle(longint g, longint acc, logic [15:0] w);
        longint v;
        longint wl;
        if (acc > QUARTER && g < -QUARTER) g += FULL;
        if (acc < -QUARTER && g > QUARTER) g -= FULL;
        wl = w;
        v = (wl * g + (65536 - wl) * acc + 32768) >>> 16;
        if (v > HALF) v -= ((v - HALF + FULL - 1) / FULL) * FULL;
        if (v < -HALF) v += ((-HALF - v + FULL - 1) / FULL) * FULL;
        return v;
    endfunction

    function automatic angles_t predict_angles(sample_row_t s);
        angles_t a;
        longint  acc_r;
        longint  acc_p;
        acc_r = accel_angle(s.ax, s.az);
        acc_p = accel_angle(s.ay, s.az);
        if (!tilt_started) begin
            roll_angle = acc_r;
            pitch_angle = acc_p;
            tilt_started = 1'b1;
        end
        else begin
            roll_angle = fuse_angle(roll_angle + gyro_delta(longint'(s.gx) * longint'(s.dt)),
                                    acc_r, gyro_w);
            pitch_angle = fuse_angle(pitch_angle + gyro_delta(-longint'(s.gy) * longint'(s.dt)),
                                     acc_p, gyro_w);
        end
        a.typed = 1'b0;
        a.roll = roll_angle[16:0];
        a.pitch = pitch_angle[16:0];
        return a;
    endfunction

    // monitor: prediction on sample accept, checking on result accept
    always @(posedge clk) begin
        angles_t p;
        angles_t t;
        angles_t e;
        if (rst_n) begin
            if (cfg.valid && cfg.ready)
                gyro_w = cfg.data;
            if (sample.valid && sample.ready) begin
                p = predict_angles('{sample.accel_x, sample.accel_y, sample.accel_z,
                                     sample.gyro_rate_x, sample.gyro_rate_y,
                                     sample.elapsed_us, 1'b0, '0, '0});
                t = typed_q.pop_front();
                angles_q.push_back(t.typed ? t : p);
            end
            if (result.valid && result.ready) begin
                if (angles_q.size() == 0) begin
                    $display("%0t: unexpected result item roll %0d pitch %0d", $time,
                             result.roll_out, result.pitch_out);
                    errors++;
                end
                else begin
                    e = angles_q.pop_front();
                    if (result.roll_out !== e.roll) begin
                        $display("%0t: roll expected %0d actual %0d", $time, e.roll,
                                 result.roll_out);
                        errors++;
                    end
                    if (result.pitch_out !== e.pitch) begin
                        $display("%0t: pitch expected %0d actual %0d", $time, e.pitch,
                                 result.pitch_out);
                        errors++;
                    end
                end
            end
        end
    end

    // receiver with random stalls and a long hold-off on request
    always @(posedge clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            result.ready <= 1'b0;
            hold_left--;
        end
        else
            result.ready <= ($urandom_range(99) >= snk_idle);
    end

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready) ||
            (cfg.valid && cfg.ready))
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= LIMIT) begin
            $display("tb_tilt_complementary_filter_top: FAIL");
            $finish;
        end
    end

    task automatic send_sample(sample_row_t s);
        angles_t t;
        t.typed = s.typed;
        t.roll = s.roll;
        t.pitch = s.pitch;
        typed_q.push_back(t);
        while ($urandom_range(99) < src_idle) begin
            sample.valid <= 1'b0;
            @(posedge clk);
        end
        sample.valid       <= 1'b1;
        sample.accel_x     <= s.ax;
        sample.accel_y     <= s.ay;
        sample.accel_z     <= s.az;
        sample.gyro_rate_x <= s.gx;
        sample.gyro_rate_y <= s.gy;
        sample.elapsed_us  <= s.dt;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
    endtask

    task automatic drain();
        sample.valid <= 1'b0;
        @(posedge clk);
        while (angles_q.size() != 0 || typed_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_weight(logic [15:0] w);
        cfg.valid <= 1'b1;
        cfg.data  <= w;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic sample_row_t random_sample();
        sample_row_t s;
        int          m;
        s.typed = 1'b0;
        s.roll = '0;
        s.pitch = '0;
        m = $urandom_range(9);
        s.ax = 16'($urandom);
        s.ay = 16'($urandom);
        s.az = 16'($urandom);
        s.gx = 16'($urandom);
        s.gy = 16'($urandom);
        s.dt = 20'($urandom);
        if (m < 6) begin
            // plausible motion: modest rates and short intervals
            s.gx = 16'($signed($urandom_range(4000)) - 2000);
            s.gy = 16'($signed($urandom_range(4000)) - 2000);
            s.dt = 20'($urandom_range(20000));
        end
        else if (m < 8) begin
            // near the half turn, to exercise the unwrap
            s.az = 16'(-$signed($urandom_range(32767)));
            s.ax = 16'($signed($urandom_range(600)) - 300);
            s.ay = 16'($signed($urandom_range(600)) - 300);
        end
        return s;
    endfunction

    sample_row_t directed[16] = '{
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd0, 1'b1, 17'sd0, 17'sd0},
        '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1000, 1'b1, 17'sd0, 17'sd0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd100, -16'sd100, 20'd1000, 1'b0, '0, '0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0, 20'd0, 1'b0, '0, '0},
        '{16'sd0, 16'sd0, -16'sd1000, 16'sd0, 16'sd0, 20'd10, 1'b0, '0, '0},
        '{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 20'd10, 1'b0, '0, '0},
        '{16'sd10, -16'sd10, -16'sd32768, 16'sd32767, -16'sd32768, 20'd1048575, 1'b0, '0, '0},
        '{-16'sd10, 16'sd10, -16'sd32768, -16'sd32768, 16'sd32767, 20'd1048575, 1'b0, '0, '0},
        '{16'sd50, 16'sd50, -16'sd20000, -16'sd8000, 16'sd8000, 20'd100000, 1'b0, '0, '0},
        '{-16'sd50, -16'sd50, -16'sd20000, 16'sd8000, -16'sd8000, 20'd100000, 1'b0, '0, '0},
        '{16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 20'd1048575, 1'b0, '0, '0},
        '{-16'sd32768, 16'sd0, 16'sd0, -16'sd32768, -16'sd32768, 20'd1048575, 1'b0, '0, '0},
        '{16'sd0, 16'sd32767, 16'sd1, 16'sd1, -16'sd1, 20'd31250, 1'b0, '0, '0},
        '{16'sd0, -16'sd32768, -16'sd1, -16'sd1, 16'sd1, 20'd31250, 1'b0, '0, '0},
        '{16'sd1, -16'sd1, 16'sd16384, 16'sd0, 16'sd0, 20'd0, 1'b0, '0, '0},
        '{-16'sd21845, 16'sd21845, 16'sd21845, 16'sd1234, -16'sd4321, 20'd699050, 1'b0, '0, '0}
    };

    logic [15:0] weights[4];

    initial begin
        rst_n = 1'b0;
        sample.valid = 1'b0;
        sample.accel_x = '0;
        sample.accel_y = '0;
        sample.accel_z = '0;
        sample.gyro_rate_x = '0;
        sample.gyro_rate_y = '0;
        sample.elapsed_us = '0;
        result.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        tilt_started = 1'b0;
        roll_angle = 0;
        pitch_angle = 0;
        gyro_w = WEIGHT_RESET;
        errors = 0;
        idle_count = 0;
        src_idle = 31;
        snk_idle = 49;
        hold_left = 0;
        hold_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_sample(directed[i]);
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            src_idle = mode == 0 ? 31 : (mode == 1 ? 49 : 0);
            snk_idle = mode == 0 ? 49 : (mode == 1 ? 31 : 0);
            weights[0] = 16'($urandom);
            weights[1] = 16'd0;
            weights[2] = 16'hFFFF;
            weights[3] = mode == 2 ? WEIGHT_RESET : ~weights[0];
            for (int k = 0; k < 4; k++) begin
                write_weight(weights[k]);
                for (int n = 0; n < 66; n++) begin
                    if (mode == 2 && k == 1 && n == 5)
                        hold_req = 1'b1;
                    send_sample(random_sample());
                end
                drain();
            end
        end

        if (errors == 0)
            $display("tb_tilt_complementary_filter_top: PASS");
        else
            $display("tb_tilt_complementary_filter_top: FAIL");
        $finish;
    end

endmodule
